// File: rtl/four_level_page_table_walker_defines.svh
// Assertion macros used by the page table walker top level.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTW_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page table walker check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page table walker check failed");

`endif

// File: rtl/ptw_pkg.sv
// Types, codes and helpers shared by the page table walker modules.
`default_nettype none
package ptw_pkg;

	localparam int VaWidth   = 48;
	localparam int AddrWidth = 52;
	localparam int IdxWidth  = 9;

	// Input operation codes.
	localparam logic OP_REQUEST  = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	// Result kinds.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_PRESENT = 3'd1;
	localparam logic [2:0] ST_READ_FAIL   = 3'd2;
	localparam logic [2:0] ST_BUSY        = 3'd3;
	localparam logic [2:0] ST_UNEXPECTED  = 3'd4;

	// Page sizes.
	localparam logic [1:0] PG_4K = 2'd0;
	localparam logic [1:0] PG_2M = 2'd1;
	localparam logic [1:0] PG_1G = 2'd2;

	// Table levels, top first.
	localparam logic [1:0] LVL_3 = 2'd3;
	localparam logic [1:0] LVL_2 = 2'd2;
	localparam logic [1:0] LVL_1 = 2'd1;
	localparam logic [1:0] LVL_0 = 2'd0;

	localparam int PresentBit = 0;
	localparam int LargeBit   = 7;

	typedef struct packed {
		logic        op;
		logic [63:0] vaddr;
		logic [63:0] entry_data;
		logic        read_ok;
	} ptw_in_t;

	typedef struct packed {
		logic                 kind;
		logic [AddrWidth-1:0] address;
		logic [2:0]           status;
		logic [1:0]           pg_size;
		logic [1:0]           fault_level;
	} ptw_out_t;

	typedef struct packed {
		logic               busy;
		logic [1:0]         level;
		logic [VaWidth-1:0] va;
	} ptw_walk_t;

	// Nine-bit table index of the saved address for a given level.
	function automatic logic [IdxWidth-1:0] va_index(input logic [VaWidth-1:0] va,
			input logic [1:0] level);
		logic [IdxWidth-1:0] idx;
		unique case (level)
			LVL_3:   idx = va[47:39];
			LVL_2:   idx = va[38:30];
			LVL_1:   idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ptw_step.sv
// Combinational walk step: forms one result and the next walk state from one item.
`default_nettype none
module ptw_step (
	input  ptw_pkg::ptw_in_t   item,
	input  ptw_pkg::ptw_walk_t walk,
	input  logic [63:0]        root_table_base,
	output ptw_pkg::ptw_out_t  result,
	output ptw_pkg::ptw_walk_t walk_nxt
);
	import ptw_pkg::*;

	logic [63:0] ent;
	logic        huge_page;

	assign ent       = item.entry_data;
	assign huge_page = ent[LargeBit];

	always_comb begin
		result.kind        = KIND_DONE;
		result.address     = '0;
		result.status      = ST_OK;
		result.pg_size     = PG_4K;
		result.fault_level = LVL_0;
		walk_nxt           = walk;

		if (item.op == OP_REQUEST) begin
			if (walk.busy) begin
				result.status      = ST_BUSY;
				result.fault_level = walk.level;
			end else begin
				walk_nxt.busy      = 1'b1;
				walk_nxt.level     = LVL_3;
				walk_nxt.va        = item.vaddr[VaWidth-1:0];
				result.kind        = KIND_READ;
				result.address     = {4'b0, root_table_base[47:12],
					item.vaddr[47:39], 3'b000};
				result.fault_level = LVL_3;
			end
		end else if (!walk.busy) begin
			result.status = ST_UNEXPECTED;
		end else if (!item.read_ok) begin
			walk_nxt.busy      = 1'b0;
			result.status      = ST_READ_FAIL;
			result.fault_level = walk.level;
		end else if (!ent[PresentBit]) begin
			walk_nxt.busy      = 1'b0;
			result.status      = ST_NOT_PRESENT;
			result.fault_level = walk.level;
		end else begin
			unique case (walk.level)
				LVL_3: begin
					walk_nxt.level     = LVL_2;
					result.kind        = KIND_READ;
					result.address     = {ent[51:12], va_index(walk.va, LVL_2), 3'b000};
					result.fault_level = LVL_2;
				end
				LVL_2: begin
					if (huge_page) begin
						walk_nxt.busy      = 1'b0;
						result.address     = {ent[51:30], walk.va[29:0]};
						result.pg_size     = PG_1G;
						result.fault_level = LVL_2;
					end else begin
						walk_nxt.level     = LVL_1;
						result.kind        = KIND_READ;
						result.address     = {ent[51:12], va_index(walk.va, LVL_1), 3'b000};
						result.fault_level = LVL_1;
					end
				end
				LVL_1: begin
					if (huge_page) begin
						walk_nxt.busy      = 1'b0;
						result.address     = {2'b00, ent[49:21], walk.va[20:0]};
						result.pg_size     = PG_2M;
						result.fault_level = LVL_1;
					end else begin
						walk_nxt.level     = LVL_0;
						result.kind        = KIND_READ;
						result.address     = {2'b00, ent[49:12], va_index(walk.va, LVL_0),
							3'b000};
						result.fault_level = LVL_0;
					end
				end
				LVL_0: begin
					// Last level: always a 4 KB page, bit 7 is not looked at.
					walk_nxt.busy      = 1'b0;
					result.address     = {2'b00, ent[49:12], walk.va[11:0]};
					result.fault_level = LVL_0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker: input register, walk state and result register.
`default_nettype none
`include "four_level_page_table_walker_defines.svh"
// The walker translates a virtual address through a four-level page table. A translate
// request (op 0) on the req channel latches the low 48 bits of the address and produces a
// read request (kind 0) for the top-level entry; the caller performs that memory read and
// returns the entry word with its read-ok flag as a response transaction (op 1). Each
// response yields either the next read request or a final result (kind 1) carrying the
// physical address, the page size (4 KB, 2 MB or 1 GB) or a fault status with the level
// at which the walk ended. Every accepted transaction produces exactly one result
// transaction on the rsp channel. A request arriving while a walk is in progress is
// dropped with a busy status, and a response arriving while idle is reported as
// unexpected; neither disturbs the walk state. The block accepts one transaction per
// clock cycle while req_stall is low; each item passes through the input register,
// where the walk state is read and updated, and then through the result register.
// The root table base is written through the cfg channel, which is always ready; it must
// only be written while no walk is in progress and no result is outstanding.
module four_level_page_table_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ptw_pkg::ptw_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ptw_pkg::ptw_out_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [63:0]       cfg_data
);
	import ptw_pkg::*;

	// Input register stage.
	logic     v_s1;
	ptw_in_t  item_s1;

	// Result register stage.
	logic     v_s2;
	ptw_out_t res_s2;

	// Architectural state of the walk and the configuration register.
	ptw_walk_t   walk_q;
	logic [63:0] root_q;

	ptw_out_t  res;
	ptw_walk_t walk_nxt;
	logic      out_free;
	logic      adv;
	logic      accept;

	// The result register can take a new result when it is empty or being drained.
	assign out_free  = !v_s2 || !rsp_stall;
	assign adv       = v_s1 && out_free;
	assign req_stall = v_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	assign cfg_ready = 1'b1;
	assign rsp_valid = v_s2;
	assign rsp       = res_s2;

	// The step logic sees the item held in the input register and the current walk
	// state; its result and new state are committed together when the item moves on.
	ptw_step u_step (
		.item            (item_s1),
		.walk            (walk_q),
		.root_table_base (root_q),
		.result          (res),
		.walk_nxt        (walk_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			walk_q <= '0;
			root_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (out_free) begin
				v_s2 <= v_s1;
			end
			if (adv) begin
				walk_q <= walk_nxt;
			end
			if (cfg_valid && cfg_ready) begin
				root_q <= cfg_data;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	// Issuing a read request always leaves the walker busy.
	`PTW_ASSERT_NEXT(a_read_keeps_busy, adv && res.kind == KIND_READ, walk_q.busy)
	// A completed translation or a fault on a response ends the walk.
	`PTW_ASSERT_NEXT(a_done_ends_walk, adv && res.kind == KIND_DONE &&
		(res.status == ST_OK || res.status == ST_NOT_PRESENT ||
		res.status == ST_READ_FAIL), !walk_q.busy)
	// A dropped request leaves the walk level untouched.
	`PTW_ASSERT_NEXT(a_busy_drop_keeps_level, adv && res.status == ST_BUSY,
		walk_q.level == $past(walk_q.level) && walk_q.busy)
	// The input side stalls only while an item waits in the input register.
	`PTW_ASSERT_SAME(a_stall_needs_item, req_stall, v_s1 && v_s2)

endmodule
`default_nettype wire
